// ===== sv/fova_pkg.sv =====
// Shared constants and types for the file offset to virtual address translator.
// No dependencies; every other file imports this package.
`default_nettype none

package fova_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int ADDR_W = 64;
  localparam int SEC_W = 32;
  localparam int INDEX_W = 4;
  localparam int OP_W = 2;

  // Operation codes carried by the op field of an input word.
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Raw file range of one table entry, kept in flip-flops next to its comparator.
  typedef struct packed {
    logic [SEC_W-1:0] raw_size;
    logic [SEC_W-1:0] raw_offset;
  } lane_t;

  // Back pressure seen by the front end.
  typedef struct packed {
    logic queue_full;
    logic back_idle;
  } front_ctl_t;

endpackage

`default_nettype wire

// ===== sv/fova_if.sv =====
// Valid/ready channel interfaces for input words, result words and configuration writes.
// Depends on fova_pkg for field widths.
`default_nettype none

interface fova_item_if import fova_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SEC_W-1:0]    section_rva;
  logic [SEC_W-1:0]    section_raw_size;
  logic [SEC_W-1:0]    section_raw_offset;
  logic [ADDR_W-1:0]   query_offset;

  modport source (
    output valid, op, section_rva, section_raw_size, section_raw_offset, query_offset,
    input  ready
  );
  modport sink (
    input  valid, op, section_rva, section_raw_size, section_raw_offset, query_offset,
    output ready
  );
endinterface

interface fova_result_if import fova_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   virtual_address;
  logic [INDEX_W-1:0]  section_index;
  logic                last;

  modport source (output valid, virtual_address, section_index, last, input ready);
  modport sink   (input valid, virtual_address, section_index, last, output ready);
endinterface

interface fova_cfg_if import fova_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/fova_front.sv =====
// Front end: image base register, section range lanes, entry count and match detection.
// Depends on fova_pkg and the channel interfaces in fova_if.sv.
`default_nettype none

module fova_front import fova_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  fova_item_if.sink                   item,
  fova_cfg_if.sink                    cfg,
  input  wire front_ctl_t             ctl,
  output logic                        push_valid,
  output logic [ADDR_W-1:0]           push_query,
  output logic [TABLE_DEPTH-1:0]      push_mask,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [ADDR_W-1:0]           wr_delta
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [ADDR_W-1:0]    image_base;
  lane_t                lane [TABLE_DEPTH];
  logic [CNT_W-1:0]     entry_count;
  logic                 accept;
  logic                 table_full;
  logic                 do_load;
  logic [TABLE_DEPTH-1:0] hit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_base <= '0;
    end else if (cfg.valid) begin
      image_base <= cfg.data;
    end
  end

  // Loads and clears rewrite entries that queued queries may still point at,
  // so they wait until the back end has drained.
  always_comb begin
    case (item.op)
      OP_LOAD:      item.ready = ctl.back_idle;
      OP_CLEAR:     item.ready = ctl.back_idle;
      OP_TRANSLATE: item.ready = !ctl.queue_full;
      default:      item.ready = 1'b1;
    endcase
  end

  assign accept = item.valid && item.ready;
  assign table_full = (entry_count == CNT_W'(TABLE_DEPTH));
  assign do_load = accept && (item.op == OP_LOAD) && !table_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept && (item.op == OP_CLEAR)) begin
      entry_count <= '0;
    end else if (do_load) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      lane[entry_count[IDX_W-1:0]] <= '{raw_size: item.section_raw_size,
                                         raw_offset: item.section_raw_offset};
    end
  end

  // One comparator per entry; the end of a range needs 33 bits.
  always_comb begin
    logic [SEC_W:0] lane_end;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lane_end = {1'b0, lane[i].raw_offset} + {1'b0, lane[i].raw_size};
      hit[i] = (CNT_W'(i) < entry_count)
            && (item.query_offset >= ADDR_W'(lane[i].raw_offset))
            && (item.query_offset < ADDR_W'(lane_end));
    end
  end

  // A query without any match produces no word and is dropped here.
  assign push_valid = accept && (item.op == OP_TRANSLATE) && (|hit);
  assign push_query = item.query_offset;
  assign push_mask = hit;

  // The back end stores mapped address minus raw offset, so a translation is one add.
  assign wr_en = do_load;
  assign wr_addr = entry_count[IDX_W-1:0];
  assign wr_delta = image_base + ADDR_W'(item.section_rva) - ADDR_W'(item.section_raw_offset);

endmodule

`default_nettype wire

// ===== sv/fova_queue.sv =====
// Short first-in first-out queue carrying query words from the front end to the back end.
// Depends on fova_pkg for its depth.
`default_nettype none

module fova_queue import fova_pkg::*; #(
  parameter int W = ADDR_W + TABLE_DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     storage [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign pop_data = storage[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      storage[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fova_back.sv =====
// Back end: walks the match mask of one query, reads the address delta memory and
// drives the result register. Depends on fova_pkg and fova_if.sv.
`default_nettype none

module fova_back import fova_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int QW = ADDR_W + TABLE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire logic [QW-1:0]       q_data,
  output logic                     q_pop,
  output logic                     busy,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_addr,
  input  wire logic [ADDR_W-1:0]   wr_delta,
  fova_result_if.source            result
);

  logic [ADDR_W-1:0]      delta_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]      work_query;
  logic [TABLE_DEPTH-1:0] work_mask;
  logic [TABLE_DEPTH-1:0] mask_rest;
  logic [IDX_W-1:0]       sel;
  logic                   s1_adv;
  logic                   out_adv;
  logic                   s2_valid;
  logic [ADDR_W-1:0]      s2_query;
  logic [ADDR_W-1:0]      s2_delta;
  logic [IDX_W-1:0]       s2_index;
  logic                   s2_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      delta_mem[wr_addr] <= wr_delta;
    end
  end

  // Lowest set bit is the next match in table order.
  always_comb begin
    sel = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (work_mask[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  assign mask_rest = work_mask & (work_mask - TABLE_DEPTH'(1));
  assign busy = (work_mask != '0);

  assign out_adv = s2_valid && (!result.valid || result.ready);
  assign s1_adv = busy && (!s2_valid || out_adv);
  assign q_pop = !q_empty && (!busy || (s1_adv && (mask_rest == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      work_mask <= '0;
      s2_valid <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        work_mask <= q_data[TABLE_DEPTH-1:0];
      end else if (s1_adv) begin
        work_mask <= mask_rest;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (out_adv) begin
        s2_valid <= 1'b0;
      end
      if (out_adv) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_query <= q_data[QW-1:TABLE_DEPTH];
    end
    if (s1_adv) begin
      s2_query <= work_query;
      s2_index <= sel;
      s2_last <= (mask_rest == '0);
      s2_delta <= delta_mem[sel];
    end
    if (out_adv) begin
      result.virtual_address <= s2_query + s2_delta;
      result.section_index <= INDEX_W'(s2_index);
      result.last <= s2_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/file_offset_to_virtual_address.sv =====
// Top level of the file offset to virtual address translator.
// Depends on fova_pkg, fova_if.sv, fova_front, fova_queue and fova_back.
//
// Usage. The item channel carries one word per operation: load a section
// (relative address, raw size, raw file offset), translate a file offset, or
// clear the table. The cfg channel writes the image base; it is always ready and
// should only be written while the block is idle. The result channel returns
// one word per section whose raw range holds the queried offset, in table
// order, with last set on the final word of that query.
//
// Timing. A load or clear is taken only once no earlier query waits in the
// queue or is being walked. A translate is taken while the two-word query
// queue has room; all entries are compared in the cycle it is taken. Its first
// result passes the queue, work mask, stage-two and result registers; further
// matches follow one per cycle while the receiver is ready, set by the single
// read port of the address delta memory. A query with no match yields no word.
//
// Reset clears the entry count, the image base, the queue and all valid flags;
// the table itself needs no clearing pass. When the receiver stalls, the result
// register holds its word, the back end stops, the queue fills, and then the
// item channel drops ready for translates and for loads or clears alike.
`default_nettype none

module file_offset_to_virtual_address import fova_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  fova_item_if.sink       item,
  fova_cfg_if.sink        cfg,
  fova_result_if.source   result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int QW = ADDR_W + TABLE_DEPTH;

  front_ctl_t              ctl;
  logic                    push_valid;
  logic [ADDR_W-1:0]       push_query;
  logic [TABLE_DEPTH-1:0]  push_mask;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]       wr_delta;
  logic                    q_full;
  logic                    q_empty;
  logic                    q_pop;
  logic [QW-1:0]           q_data;
  logic                    back_busy;

  // The back end is idle only when no query waits in the queue or is being walked.
  assign ctl.queue_full = q_full;
  assign ctl.back_idle = q_empty && !back_busy;

  fova_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .ctl        (ctl),
    .push_valid (push_valid),
    .push_query (push_query),
    .push_mask  (push_mask),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_delta   (wr_delta)
  );

  fova_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data ({push_query, push_mask}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  fova_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .QW          (QW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .busy     (back_busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_delta (wr_delta),
    .result   (result)
  );

  // A table write must never overlap a query that is still in flight.
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (q_empty && !back_busy))
    else $error("table written while a query is in flight");

  // A query is only pushed when the queue has room.
  assert property (@(posedge clk) disable iff (rst)
    push_valid |-> !q_full)
    else $error("query pushed into a full queue");

  // No result word may be presented right after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  // The queue is never popped while empty.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("query queue popped while empty");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the file offset to virtual address translator.
// Depends on fova_pkg, the channel interfaces in fova_if.sv and the top level RTL.
`default_nettype none

module tb_top;
  import fova_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEFAULT;
  localparam int LIMIT_CYCLES = 300000;
  // Cycles to let the back end finish a query that may have produced no word.
  localparam int SETTLE_CYCLES = 24;
  // The fourth op code selects nothing; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SEC_W-1:0]  rva;
    logic [SEC_W-1:0]  raw_size;
    logic [SEC_W-1:0]  raw_offset;
    logic [ADDR_W-1:0] query;
  } section_word_t;

  typedef struct {
    logic [ADDR_W-1:0]  va;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } xlat_result_t;

  logic clk = 1'b0;
  logic rst;

  fova_item_if   item_ch ();
  fova_cfg_if    cfg_ch ();
  fova_result_if result_ch ();

  file_offset_to_virtual_address #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .cfg    (cfg_ch),
    .result (result_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the section table and the image base.
  logic [ADDR_W-1:0] tbl_mapped [DEPTH];
  logic [SEC_W-1:0]  tbl_size   [DEPTH];
  logic [SEC_W-1:0]  tbl_off    [DEPTH];
  int                tbl_count;
  logic [ADDR_W-1:0] base_shadow;

  xlat_result_t pending_xlat [$];

  int error_count = 0;
  int cycle_count = 0;
  bit src_idle_en = 1'b0;
  bit snk_idle_en = 1'b0;
  int hold_cycles = 0;

  // Updates the shadow table for one accepted word and queues the translations it causes.
  task automatic predict_word(input section_word_t w);
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    xlat_result_t      r;
    xlat_result_t      hits [$];
    case (w.op)
      OP_LOAD: begin
        if (tbl_count < DEPTH) begin
          tbl_mapped[tbl_count] = base_shadow + {32'b0, w.rva};
          tbl_size[tbl_count] = w.raw_size;
          tbl_off[tbl_count] = w.raw_offset;
          tbl_count++;
        end
      end
      OP_CLEAR: begin
        tbl_count = 0;
      end
      OP_TRANSLATE: begin
        for (int i = 0; i < tbl_count; i++) begin
          // The raw range end is computed wider than 32 bits, so it never wraps.
          start = {32'b0, tbl_off[i]};
          stop = start + {32'b0, tbl_size[i]};
          if (w.query >= start && w.query < stop) begin
            r.va = w.query - start + tbl_mapped[i];
            r.idx = i[INDEX_W-1:0];
            r.last = 1'b0;
            hits.push_back(r);
          end
        end
        if (hits.size() > 0) begin
          hits[hits.size()-1].last = 1'b1;
        end
        foreach (hits[k]) begin
          pending_xlat.push_back(hits[k]);
        end
      end
      default: ;
    endcase
  endtask

  // Offers one word after a random gap and predicts it once the block takes it.
  // Valid stays high between back-to-back words.
  task automatic send_word(input section_word_t w);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= w.op;
    item_ch.section_rva <= w.rva;
    item_ch.section_raw_size <= w.raw_size;
    item_ch.section_raw_offset <= w.raw_offset;
    item_ch.query_offset <= w.query;
    do @(posedge clk); while (!item_ch.ready);
    predict_word(w);
  endtask

  // Unused fields carry random values so the block is seen to ignore them.
  task automatic load_section(input logic [SEC_W-1:0] rva, input logic [SEC_W-1:0] size,
                              input logic [SEC_W-1:0] off);
    send_word('{op: OP_LOAD, rva: rva, raw_size: size, raw_offset: off,
                query: {$urandom, $urandom}});
  endtask

  task automatic translate_offset(input logic [ADDR_W-1:0] q);
    send_word('{op: OP_TRANSLATE, rva: $urandom, raw_size: $urandom, raw_offset: $urandom,
                query: q});
  endtask

  task automatic send_op(input logic [OP_W-1:0] op);
    send_word('{op: op, rva: $urandom, raw_size: $urandom, raw_offset: $urandom,
                query: {$urandom, $urandom}});
  endtask

  // Waits until every predicted word has arrived and the back end has gone quiet.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    base_shadow = value;
  endtask

  // Empty table, the unused op code, and the image base at its reset value.
  task automatic test_empty_table();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    translate_offset('0);
    send_op(OP_UNUSED);
    send_op(OP_CLEAR);
    translate_offset('1);
    load_section(32'h0000_1000, 32'h0000_0010, 32'h0000_0200);
    translate_offset(64'h208);
    drain_results();
  endtask

  // Sixteen overlapping sections with the base at all ones, so mapped addresses wrap.
  // One query hits every entry; a load into the full table must be dropped.
  task automatic test_full_table();
    write_base('1);
    send_op(OP_CLEAR);
    for (int i = 0; i < DEPTH - 1; i++) begin
      load_section(i * 32'h0001_0000, 32'h0000_1000, 32'h0000_1000 + i);
    end
    load_section('1, '1, '0);
    load_section('0, 32'h1, 32'h0000_1800);
    translate_offset(64'h1800);
    translate_offset('0);
    translate_offset(64'hFFFF_FFFE);
    translate_offset(64'hFFFF_FFFF);
    translate_offset('1);
    drain_results();
  endtask

  // A range reaching past 2^32, and a section of size zero that never matches.
  task automatic test_range_edges();
    write_base(64'h8000_0000_0000_0000);
    send_op(OP_CLEAR);
    load_section('1, '1, '1);
    load_section('0, '0, 32'h100);
    translate_offset(64'h1_FFFF_FFFD);
    translate_offset(64'h1_FFFF_FFFE);
    translate_offset(64'h100);
    drain_results();
  endtask

  // The receiver stops for a long stretch while queries keep coming back to back,
  // so the result register and the query queue fill and the input stalls.
  task automatic test_receiver_hold();
    write_base({$urandom, $urandom});
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    send_op(OP_CLEAR);
    load_section($urandom, 32'h100, 32'h40);
    load_section($urandom, 32'h100, 32'h80);
    hold_cycles = 200;
    for (int i = 0; i < 10; i++) begin
      translate_offset(64'h80 + $urandom_range(0, 63));
    end
    load_section($urandom, 32'h10, 32'h90);
    translate_offset(64'h98);
    drain_results();
  endtask

  // Random traffic in phases, each with its own image base and idling mix.
  // Most queries aim at loaded sections, with their edges hit on purpose.
  task automatic test_random_traffic();
    int unsigned pick;
    int          j;
    logic [ADDR_W-1:0] q;
    logic [SEC_W-1:0]  off;
    logic [SEC_W-1:0]  size;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_base('0);
        1: write_base('1);
        default: write_base({$urandom, $urandom});
      endcase
      src_idle_en = (phase != 0) && ($urandom_range(0, 3) != 0);
      snk_idle_en = (phase != 0) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 14; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          off = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 16'h3FFF);
          size = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 16'h2000);
          load_section($urandom, size, off);
        end else if (pick < 90) begin
          if (tbl_count > 0 && $urandom_range(0, 4) != 0) begin
            j = $urandom_range(0, tbl_count - 1);
            case ($urandom_range(0, 3))
              0: q = {32'b0, tbl_off[j]};
              1: q = {32'b0, tbl_off[j]} + {32'b0, tbl_size[j]};
              2: q = {32'b0, tbl_off[j]} - 64'd1;
              default: q = {32'b0, tbl_off[j]} + $urandom_range(0, tbl_size[j]);
            endcase
          end else begin
            q = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 16'h5FFF));
          end
          translate_offset(q);
        end else if (pick < 95) begin
          send_op(OP_CLEAR);
        end else begin
          send_op(OP_UNUSED);
        end
      end
    end
    drain_results();
  endtask

  // Result receiver: a random stall before each word, or one long hold on request.
  initial begin : result_sink
    int stall;
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = snk_idle_en ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Every result word is matched against the oldest predicted translation.
  always @(posedge clk) begin : check_results
    xlat_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_xlat.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual va=%h index=%0d last=%b",
                 $time, result_ch.virtual_address, result_ch.section_index, result_ch.last);
        error_count++;
      end else begin
        want = pending_xlat.pop_front();
        if (result_ch.virtual_address !== want.va) begin
          $display("%0t: virtual_address expected %h actual %h",
                   $time, want.va, result_ch.virtual_address);
          error_count++;
        end
        if (result_ch.section_index !== want.idx) begin
          $display("%0t: section_index expected %0d actual %0d",
                   $time, want.idx, result_ch.section_index);
          error_count++;
        end
        if (result_ch.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, result_ch.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.op <= OP_LOAD;
    item_ch.section_rva <= '0;
    item_ch.section_raw_size <= '0;
    item_ch.section_raw_offset <= '0;
    item_ch.query_offset <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    tbl_count = 0;
    base_shadow = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_full_table();
    test_range_edges();
    test_receiver_hold();
    test_random_traffic();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
